### design/sbe_pkg.sv
package sbe_pkg;

  localparam int StackDepthDefault   = 1024;
  localparam int VarSlotsDefault     = 128;
  localparam int ProgramDepthDefault = 4096;

  localparam int CmdW     = 5;
  localparam int OperandW = 12;
  localparam int DataW    = 32;
  localparam int FaultW   = 3;
  localparam int VarCodeW = 7;

  typedef enum logic [CmdW-1:0] {
    OP_CONST  = 5'd0,
    OP_ADD    = 5'd1,
    OP_SUB    = 5'd2,
    OP_MUL    = 5'd3,
    OP_DIV    = 5'd4,
    OP_EQ     = 5'd5,
    OP_NE     = 5'd6,
    OP_LT     = 5'd7,
    OP_LE     = 5'd8,
    OP_GT     = 5'd9,
    OP_GE     = 5'd10,
    OP_LOAD   = 5'd11,
    OP_SET    = 5'd12,
    OP_DEFINE = 5'd13,
    OP_PRINT  = 5'd14,
    OP_JFALSE = 5'd15,
    OP_JUMP   = 5'd16,
    OP_HALT   = 5'd17
  } opcode_t;

  localparam logic [FaultW-1:0] FAULT_NONE   = 3'd0;
  localparam logic [FaultW-1:0] FAULT_UNDER  = 3'd1;
  localparam logic [FaultW-1:0] FAULT_OVER   = 3'd2;
  localparam logic [FaultW-1:0] FAULT_DIV0   = 3'd3;
  localparam logic [FaultW-1:0] FAULT_OPCODE = 3'd4;
  localparam logic [FaultW-1:0] FAULT_UNDEF  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;    // capture the request fields
    logic rd_top;      // read the top two stack entries and the variable slot
    logic execute;     // decide and commit the instruction
    logic div_start;   // start the divider
  } sbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;    // latched instruction is a legal division
    logic div_busy;
    logic div_done;
  } sbe_stat_t;

endpackage

### design/sbe_div.sv
module sbe_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [sbe_pkg::DataW-1:0] dividend,
  input  logic [sbe_pkg::DataW-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [sbe_pkg::DataW-1:0] quotient
);

  localparam int W = sbe_pkg::DataW;

  logic [W-1:0]         rem;
  logic [W-1:0]         quo;
  logic [W-1:0]         dvs;
  logic                 neg;
  logic [$clog2(W):0]   cnt;
  logic [W:0]           trial;
  logic [W:0]           shifted;

  assign shifted = {rem, quo[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(W)+1)'(W);
        neg  <= dividend[W-1] ^ divisor[W-1];
        quo  <= dividend[W-1] ? (W'(0) - dividend) : dividend;
        dvs  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(W)+1)'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (W'(0) - quo) : quo;

endmodule

### design/sbe_datapath.sv
module sbe_datapath #(
  parameter int STACK_DEPTH   = sbe_pkg::StackDepthDefault,
  parameter int VAR_SLOTS     = sbe_pkg::VarSlotsDefault,
  parameter int PROGRAM_DEPTH = sbe_pkg::ProgramDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sbe_pkg::sbe_cmd_t           ctl,
  output sbe_pkg::sbe_stat_t          stat,
  input  logic [sbe_pkg::CmdW-1:0]    in_cmd,
  input  logic [sbe_pkg::OperandW-1:0] in_operand,
  input  logic [sbe_pkg::DataW-1:0]   in_const,
  output logic                        res_print_valid,
  output logic [sbe_pkg::DataW-1:0]   res_print_value,
  output logic [sbe_pkg::OperandW-1:0] res_next_addr,
  output logic                        res_halted,
  output logic [sbe_pkg::FaultW-1:0]  res_fault
);

  localparam int W    = sbe_pkg::DataW;
  localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW  = $clog2(STACK_DEPTH + 1);
  localparam int VAW  = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam int PAW  = $clog2(PROGRAM_DEPTH);
  localparam int OW   = sbe_pkg::OperandW;

  logic [W-1:0]     stack_mem [STACK_DEPTH];
  logic [W-1:0]     var_mem   [VAR_SLOTS];
  logic [VAR_SLOTS-1:0] var_def;

  logic [SCW-1:0]   stack_count;
  logic [PAW-1:0]   instr_pointer;
  logic             stopped;

  logic [sbe_pkg::CmdW-1:0] cmd;
  logic [OW-1:0]    operand;
  logic [W-1:0]     const_value;
  logic [W-1:0]     top_b;
  logic [W-1:0]     top_a;
  logic [W-1:0]     var_rd;

  logic             div_busy;
  logic             div_done;
  logic [W-1:0]     div_q;
  logic [W-1:0]     prod;

  logic [sbe_pkg::VarCodeW-1:0] var_code;
  logic [VAW-1:0]   var_idx;
  logic             var_ok;
  logic             has1;
  logic             has2;
  logic             full;
  logic [SAW-1:0]   idx_b;
  logic [SAW-1:0]   idx_a;
  logic [SAW-1:0]   idx_push;

  logic             ok;
  logic [sbe_pkg::FaultW-1:0] fault_next;
  logic [SCW-1:0]   count_next;
  logic [PAW-1:0]   target;
  logic [PAW-1:0]   next_ip;
  logic             wr_en;
  logic [SAW-1:0]   wr_idx;
  logic [W-1:0]     wr_data;
  logic             var_wr;
  logic             pvalid_next;
  logic             halt_next;
  logic             lt_ab;
  logic             lt_ba;
  logic [W-1:0]     bin_res;

  assign var_code = operand[sbe_pkg::VarCodeW-1:0];
  assign var_idx  = VAW'(var_code);
  assign var_ok   = 32'(var_code) < 32'(VAR_SLOTS);
  assign has1     = stack_count >= SCW'(1);
  assign has2     = stack_count >= SCW'(2);
  assign full     = stack_count >= SCW'(STACK_DEPTH);
  assign idx_b    = SAW'(stack_count - SCW'(1));
  assign idx_a    = SAW'(stack_count - SCW'(2));
  assign idx_push = SAW'(stack_count);
  assign target   = PAW'(operand);
  assign lt_ab    = $signed(top_a) < $signed(top_b);
  assign lt_ba    = $signed(top_b) < $signed(top_a);
  assign prod     = top_a * top_b;

  assign stat.need_div = (cmd == sbe_pkg::OP_DIV) && !stopped && has2 && (top_b != '0);
  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  sbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (top_a),
    .divisor  (top_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    unique case (cmd)
      sbe_pkg::OP_ADD: bin_res = top_a + top_b;
      sbe_pkg::OP_SUB: bin_res = top_a - top_b;
      sbe_pkg::OP_MUL: bin_res = prod;
      sbe_pkg::OP_DIV: bin_res = div_q;
      sbe_pkg::OP_EQ:  bin_res = W'(top_a == top_b);
      sbe_pkg::OP_NE:  bin_res = W'(top_a != top_b);
      sbe_pkg::OP_LT:  bin_res = W'(lt_ab);
      sbe_pkg::OP_LE:  bin_res = W'(!lt_ba);
      sbe_pkg::OP_GT:  bin_res = W'(lt_ba);
      default:         bin_res = W'(!lt_ab);
    endcase
  end

  always_comb begin
    fault_next  = sbe_pkg::FAULT_NONE;
    count_next  = stack_count;
    next_ip     = (instr_pointer == PAW'(PROGRAM_DEPTH - 1)) ? '0 : instr_pointer + PAW'(1);
    wr_en       = 1'b0;
    wr_idx      = idx_push;
    wr_data     = const_value;
    var_wr      = 1'b0;
    pvalid_next = 1'b0;
    halt_next   = 1'b0;
    priority case (1'b1)
      cmd == sbe_pkg::OP_CONST: begin
        if (full) fault_next = sbe_pkg::FAULT_OVER;
        else begin
          wr_en = 1'b1;
          count_next = stack_count + SCW'(1);
        end
      end
      cmd <= sbe_pkg::OP_GE: begin
        if (!has2) fault_next = sbe_pkg::FAULT_UNDER;
        else if (cmd == sbe_pkg::OP_DIV && top_b == '0) fault_next = sbe_pkg::FAULT_DIV0;
        else begin
          wr_en = 1'b1;
          wr_idx = idx_a;
          wr_data = bin_res;
          count_next = stack_count - SCW'(1);
        end
      end
      cmd == sbe_pkg::OP_LOAD: begin
        if (full) fault_next = sbe_pkg::FAULT_OVER;
        else if (!var_ok || !var_def[var_idx]) fault_next = sbe_pkg::FAULT_UNDEF;
        else begin
          wr_en = 1'b1;
          wr_data = var_rd;
          count_next = stack_count + SCW'(1);
        end
      end
      cmd == sbe_pkg::OP_SET || cmd == sbe_pkg::OP_DEFINE: begin
        if (!has1) fault_next = sbe_pkg::FAULT_UNDER;
        else if (!var_ok || (cmd == sbe_pkg::OP_SET && !var_def[var_idx]))
          fault_next = sbe_pkg::FAULT_UNDEF;
        else begin
          var_wr = 1'b1;
          count_next = stack_count - SCW'(1);
        end
      end
      cmd == sbe_pkg::OP_PRINT: begin
        if (!has1) fault_next = sbe_pkg::FAULT_UNDER;
        else begin
          pvalid_next = 1'b1;
          count_next = stack_count - SCW'(1);
        end
      end
      cmd == sbe_pkg::OP_JFALSE: begin
        if (!has1) fault_next = sbe_pkg::FAULT_UNDER;
        else begin
          count_next = stack_count - SCW'(1);
          if (top_b == '0) next_ip = target;
        end
      end
      cmd == sbe_pkg::OP_JUMP: next_ip = target;
      cmd == sbe_pkg::OP_HALT: halt_next = 1'b1;
      default: fault_next = sbe_pkg::FAULT_OPCODE;
    endcase
    ok = fault_next == sbe_pkg::FAULT_NONE;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd         <= in_cmd;
      operand     <= in_operand;
      const_value <= in_const;
    end
    if (ctl.rd_top) begin
      top_b  <= stack_mem[SAW'(stack_count - SCW'(1))];
      top_a  <= stack_mem[SAW'(stack_count - SCW'(2))];
      var_rd <= var_mem[VAW'(operand[sbe_pkg::VarCodeW-1:0])];
    end
    if (ctl.execute && !stopped) begin
      if (wr_en) stack_mem[wr_idx] <= wr_data;
      if (var_wr && var_ok) var_mem[var_idx] <= top_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      instr_pointer <= '0;
      stopped       <= 1'b0;
      var_def       <= '0;
    end else if (ctl.execute) begin
      if (stopped) begin
        res_print_valid <= 1'b0;
        res_print_value <= '0;
        res_next_addr   <= OW'(instr_pointer);
        res_halted      <= 1'b1;
        res_fault       <= sbe_pkg::FAULT_NONE;
      end else begin
        res_print_valid <= pvalid_next;
        res_print_value <= pvalid_next ? top_b : '0;
        res_fault       <= fault_next;
        res_halted      <= !ok || halt_next;
        res_next_addr   <= ok ? OW'(next_ip) : OW'(instr_pointer);
        if (ok) begin
          stack_count   <= count_next;
          instr_pointer <= next_ip;
          if (var_wr) var_def[var_idx] <= 1'b1;
        end
        stopped <= !ok || halt_next;
      end
    end
  end

endmodule

### design/sbe_ctrl.sv
module sbe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sbe_pkg::sbe_cmd_t  ctl,
  input  sbe_pkg::sbe_stat_t stat
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_DWAIT, S_EXEC} state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.latch_in  = in_valid && in_ready;
    ctl.rd_top    = (state == S_READ);
    ctl.div_start = (state == S_DIV);
    ctl.execute   = (state == S_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EXEC && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: state <= S_DIV;
        S_DIV: begin
          if (stat.need_div) state <= S_DWAIT;
          else state <= S_EXEC;
        end
        S_DWAIT: if (stat.div_done) state <= S_EXEC;
        S_EXEC: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/stack_bytecode_executor_unit.sv
// Channel | Direction | tdata fields (low bit up)                    | tuser
// s_axis  | in        | cmd[4:0], operand[16:5], const_value[48:17]  | none
// m_axis  | out       | print_valid, print_value, next_addr, halted, | none
//         |           | fault[48:46]                                 |
// Without a divide, a taken request passes through the stack and variable read,
// decode and commit steps before its result is valid, and the next request can
// be taken in the cycle after the commit; requests do not overlap.
// A divide adds a wait for the 32 iterations of the shift-subtract divider and
// for the controller to see it finish.
// Reset clears the stack count, instruction pointer, stop flag and defined bits.
// While a result waits, the next request is still taken and runs up to its
// commit step, where it waits until the pending result is taken.
module stack_bytecode_executor_unit #(
  parameter int STACK_DEPTH   = sbe_pkg::StackDepthDefault,
  parameter int VAR_SLOTS     = sbe_pkg::VarSlotsDefault,
  parameter int PROGRAM_DEPTH = sbe_pkg::ProgramDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // cmd, operand, const_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // print_valid, print_value, next_addr, halted, fault
);

  sbe_pkg::sbe_cmd_t  ctl;
  sbe_pkg::sbe_stat_t stat;
  logic               pv;
  logic [31:0]        pval;
  logic [11:0]        naddr;
  logic               hlt;
  logic [2:0]         flt;

  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctl       (ctl),
    .stat      (stat)
  );

  sbe_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .VAR_SLOTS     (VAR_SLOTS),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (s_axis_tdata[4:0]),
    .in_operand      (s_axis_tdata[16:5]),
    .in_const        (s_axis_tdata[48:17]),
    .res_print_valid (pv),
    .res_print_value (pval),
    .res_next_addr   (naddr),
    .res_halted      (hlt),
    .res_fault       (flt)
  );

  assign m_axis_tdata = {7'd0, flt, hlt, naddr, pval, pv};

endmodule
